### design/mrr_pkg.sv
package mrr_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BRACE_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_UNIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_TYPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LO_BYTE_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LO_WORD_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 3'd5;

    localparam logic [1:0] FN_ARM  = 2'd0;
    localparam logic [1:0] FN_BYTE = 2'd1;
    localparam logic [1:0] FN_TICK = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CRC_ERR   = 3'd1;
    localparam logic [2:0] ST_EXCEPTION = 3'd2;
    localparam logic [2:0] ST_UNIT_ERR  = 3'd3;
    localparam logic [2:0] ST_SIZE_ERR  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;

    localparam logic [2:0] VT_U16   = 3'd0;
    localparam logic [2:0] VT_I16   = 3'd1;
    localparam logic [2:0] VT_FLOAT = 3'd4;

    localparam logic [7:0]  EXC_FLAG  = 8'h80;
    localparam logic [7:0]  BIN_OPEN  = 8'h7B;
    localparam logic [7:0]  BIN_CLOSE = 8'h7D;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd2000;
    localparam logic [7:0]  DEFAULT_UNIT    = 8'd1;

    typedef struct packed {
        logic        brace_mode;
        logic [7:0]  expected_unit;
        logic [2:0]  value_type;
        logic        lo_byte_first;
        logic        lo_word_first;
        logic [15:0] timeout_ms;
    } mrr_cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [7:0]  exception_code;
    } mrr_result_t;

    function automatic logic [15:0] mrr_crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] mrr_word(input logic lo_first, input logic [7:0] a,
                                             input logic [7:0] b);
        return lo_first ? {b, a} : {a, b};
    endfunction

endpackage

### design/mrr_parser.sv
module mrr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic [1:0]          func,
    input  logic [7:0]          rx_byte,
    input  mrr_pkg::mrr_cfg_t   cfg,
    output logic                res_valid,
    output mrr_pkg::mrr_result_t res
);
    import mrr_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_FIRST = 6'b000010,
        PH_UNIT  = 6'b000100,
        PH_FUNC  = 6'b001000,
        PH_COUNT = 6'b010000,
        PH_BODY  = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        waiting_reg, waiting_next;
    logic [8:0]  frame_count_reg, frame_count_next;
    logic [7:0]  data_len_reg, data_len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  unit_seen_reg, unit_seen_next;
    logic [7:0]  func_seen_reg, func_seen_next;
    logic [7:0]  data_reg [4];
    logic [7:0]  data_next [4];
    logic [15:0] elapsed_reg, elapsed_next;

    logic [15:0] crc_upd;
    logic [15:0] elapsed_inc;
    logic [8:0]  dlen;
    logic [9:0]  total;
    logic [9:0]  count_inc;
    logic        func_ok;
    logic        clear_frame;
    logic        finish;
    logic [15:0] w1;
    logic [15:0] w2;
    mrr_result_t fin_res;

    assign crc_upd     = mrr_crc_next(crc_reg, rx_byte);
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign dlen        = func_seen_reg[7] ? 9'd0 : {1'b0, data_len_reg};
    assign total       = {1'b0, dlen} + 10'd2 + {9'd0, cfg.brace_mode};
    assign count_inc   = {1'b0, frame_count_reg} + 10'd1;
    assign func_ok     = (func_seen_reg == 8'd3) || (func_seen_reg == 8'd4)
                         || ((func_seen_reg & EXC_FLAG) != 8'd0);
    assign w1 = mrr_word(cfg.lo_byte_first, data_reg[0], data_reg[1]);
    assign w2 = mrr_word(cfg.lo_byte_first, data_reg[2], data_reg[3]);

    // Result of a complete frame; crc_next already holds the final residue.
    always_comb
    begin
        fin_res = '0;
        if (crc_next != 16'd0) begin
            fin_res.status = ST_CRC_ERR;
        end else if (func_seen_reg[7]) begin
            fin_res.status = ST_EXCEPTION;
            fin_res.exception_code = data_len_reg;
        end else if (unit_seen_reg != cfg.expected_unit) begin
            fin_res.status = ST_UNIT_ERR;
        end else if (cfg.value_type == VT_U16 || cfg.value_type == VT_I16) begin
            if (data_len_reg != 8'd2) begin
                fin_res.status = ST_SIZE_ERR;
            end else begin
                fin_res.status = ST_OK;
                fin_res.value = {((cfg.value_type == VT_I16 && w1[15]) ? 16'hFFFF : 16'h0000),
                                 w1};
            end
        end else if (cfg.value_type <= VT_FLOAT) begin
            if (data_len_reg != 8'd4) begin
                fin_res.status = ST_SIZE_ERR;
            end else begin
                fin_res.status = ST_OK;
                fin_res.value = cfg.lo_word_first ? {w2, w1} : {w1, w2};
            end
        end else begin
            fin_res.status = ST_SIZE_ERR;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        waiting_next     = waiting_reg;
        frame_count_next = frame_count_reg;
        data_len_next    = data_len_reg;
        crc_next         = crc_reg;
        unit_seen_next   = unit_seen_reg;
        func_seen_next   = func_seen_reg;
        data_next        = data_reg;
        elapsed_next     = elapsed_reg;
        clear_frame      = 1'b0;
        finish           = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        if (item_valid) begin
            case (func)
                FN_ARM:
                begin
                    waiting_next = 1'b1;
                    elapsed_next = 16'd0;
                    clear_frame  = 1'b1;
                end
                FN_BYTE:
                begin
                    if (waiting_reg) begin
                        case (phase_reg)
                            PH_FIRST:
                            begin
                                if (rx_byte != 8'd0) begin
                                    if (cfg.brace_mode) begin
                                        if (rx_byte == BIN_OPEN) begin
                                            phase_next   = PH_UNIT;
                                            elapsed_next = 16'd0;
                                        end
                                    end else begin
                                        unit_seen_next = rx_byte;
                                        crc_next       = crc_upd;
                                        phase_next     = PH_FUNC;
                                        elapsed_next   = 16'd0;
                                    end
                                end
                            end
                            PH_UNIT:
                            begin
                                unit_seen_next = rx_byte;
                                crc_next       = crc_upd;
                                phase_next     = PH_FUNC;
                            end
                            PH_FUNC:
                            begin
                                func_seen_next = rx_byte;
                                crc_next       = crc_upd;
                                phase_next     = PH_COUNT;
                            end
                            PH_COUNT:
                            begin
                                if (!func_ok) begin
                                    clear_frame = 1'b1;
                                end else begin
                                    data_len_next    = rx_byte;
                                    crc_next         = crc_upd;
                                    frame_count_next = 9'd0;
                                    phase_next       = PH_BODY;
                                    elapsed_next     = 16'd0;
                                end
                            end
                            PH_BODY:
                            begin
                                if (frame_count_reg < dlen) begin
                                    if (frame_count_reg < 9'd4) begin
                                        data_next[frame_count_reg[1:0]] = rx_byte;
                                    end
                                    crc_next = crc_upd;
                                end else if ({1'b0, frame_count_reg} < {1'b0, dlen} + 10'd2) begin
                                    crc_next = crc_upd;
                                end else if (rx_byte != BIN_CLOSE) begin
                                    clear_frame = 1'b1;
                                end
                                if (!clear_frame) begin
                                    frame_count_next = count_inc[8:0];
                                    if (count_inc >= total) begin
                                        finish = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                FN_TICK:
                begin
                    if (waiting_reg) begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= cfg.timeout_ms) begin
                            waiting_next = 1'b0;
                            clear_frame  = 1'b1;
                            res_valid    = 1'b1;
                            res.status   = ST_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (clear_frame) begin
            phase_next       = PH_FIRST;
            frame_count_next = 9'd0;
            data_len_next    = 8'd0;
            crc_next         = CRC_INIT;
            unit_seen_next   = 8'd0;
            func_seen_next   = 8'd0;
            for (int i = 0; i < 4; i++) begin
                data_next[i] = 8'd0;
            end
        end
        if (finish) begin
            waiting_next = 1'b0;
            res_valid    = 1'b1;
            res          = fin_res;
        end
        if (res_valid) begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            waiting_reg     <= 1'b0;
            frame_count_reg <= 9'd0;
            data_len_reg    <= 8'd0;
            crc_reg         <= CRC_INIT;
            unit_seen_reg   <= 8'd0;
            func_seen_reg   <= 8'd0;
            elapsed_reg     <= 16'd0;
            for (int i = 0; i < 4; i++) begin
                data_reg[i] <= 8'd0;
            end
        end else begin
            phase_reg       <= phase_next;
            waiting_reg     <= waiting_next;
            frame_count_reg <= frame_count_next;
            data_len_reg    <= data_len_next;
            crc_reg         <= crc_next;
            unit_seen_reg   <= unit_seen_next;
            func_seen_reg   <= func_seen_next;
            elapsed_reg     <= elapsed_next;
            data_reg        <= data_next;
        end
    end

endmodule

### design/mrr_out_buf.sv
module mrr_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mrr_pkg::mrr_result_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mrr_pkg::mrr_result_t out_data
);
    import mrr_pkg::*;

    logic        head_v_reg, head_v_next;
    logic        skid_v_reg, skid_v_next;
    mrr_result_t head_reg, head_next;
    mrr_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = head_v_reg && !out_stall;
    assign full      = skid_v_reg;
    assign out_valid = head_v_reg;
    assign out_data  = head_reg;

    always_comb
    begin
        head_v_next = head_v_reg;
        skid_v_next = skid_v_reg;
        head_next   = head_reg;
        skid_next   = skid_reg;
        if (head_v_reg && !pop) begin
            if (push) begin
                skid_v_next = 1'b1;
                skid_next   = push_data;
            end
        end else if (skid_v_reg) begin
            head_v_next = 1'b1;
            head_next   = skid_reg;
            skid_v_next = push;
            skid_next   = push_data;
        end else begin
            head_v_next = push;
            head_next   = push_data;
            skid_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            head_v_reg <= head_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

### design/modbus_response_receiver.sv
// Modbus response receiver.
// Input channel (in_valid/in_stall): one item per cycle unless stalled; func
// selects arm, received byte (rx_byte) or one ms tick. An arm starts a new response.
// Output channel (out_valid/out_stall): one item per finished frame or
// timeout, carrying status, value and exception_code.
// The result of the item that completes a frame, or of a tick that times
// out, is registered in the output buffer before it shows on out_valid.
// Throughput: one input item per cycle while in_stall is low; the frame state
// and the byte-wide CRC update sit in one register stage.
// Stall: a two-entry output buffer holds results while out_stall is high;
// in_stall rises only when both entries are full.
// Configuration: cfg_we/cfg_index/cfg_data write registers 0..5 (framing,
// expected unit, value type, byte order, word order, timeout); write only
// while idle. Indexes 6 and 7 are ignored.
// Reset: registers return to defaults (unit 1, timeout 2000), the receiver
// is not armed and the output buffer is empty.
module modbus_response_receiver (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   status,
    output logic [31:0]                  value,
    output logic [7:0]                   exception_code,
    input  logic                         cfg_we,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mrr_pkg::*;

    mrr_cfg_t    cfg_reg;
    logic        accept;
    logic        res_valid;
    mrr_result_t res;
    mrr_result_t out_data;
    logic        full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.brace_mode     <= 1'b0;
            cfg_reg.expected_unit  <= DEFAULT_UNIT;
            cfg_reg.value_type     <= VT_U16;
            cfg_reg.lo_byte_first  <= 1'b0;
            cfg_reg.lo_word_first  <= 1'b0;
            cfg_reg.timeout_ms     <= DEFAULT_TIMEOUT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BRACE_MODE:     cfg_reg.brace_mode     <= cfg_data[0];
                REG_EXPECTED_UNIT:  cfg_reg.expected_unit  <= cfg_data[7:0];
                REG_VALUE_TYPE:     cfg_reg.value_type     <= cfg_data[2:0];
                REG_LO_BYTE_FIRST:  cfg_reg.lo_byte_first  <= cfg_data[0];
                REG_LO_WORD_FIRST:  cfg_reg.lo_word_first  <= cfg_data[0];
                REG_TIMEOUT_MS:     cfg_reg.timeout_ms     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    mrr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (accept),
        .func       (func),
        .rx_byte    (rx_byte),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    mrr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status         = out_data.status;
    assign value          = out_data.value;
    assign exception_code = out_data.exception_code;

endmodule

### dv/reply_checker.sv
module reply_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [7:0]                     rx_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [2:0]                     status,
    input  logic [31:0]                    value,
    input  logic [7:0]                     exception_code,
    input  logic                           cfg_we,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             outstanding
);
    import mrr_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_FIRST = 6'b000010,
        PH_UNIT  = 6'b000100,
        PH_FUNC  = 6'b001000,
        PH_COUNT = 6'b010000,
        PH_BODY  = 6'b100000
    } rx_phase_t;

    mrr_cfg_t    cfg;
    logic        armed;
    rx_phase_t   ph;
    int          body_pos;
    logic [7:0]  count_byte;
    logic [15:0] crc_run;
    logic [7:0]  unit_got;
    logic [7:0]  fn_got;
    logic [7:0]  payload [4];
    logic [15:0] idle_ticks;
    mrr_result_t pending_replies [$];
    mrr_result_t want;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ d[k])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic logic [15:0] pair(input logic [7:0] a, input logic [7:0] b);
        if (cfg.lo_byte_first)
            return {b, a};
        return {a, b};
    endfunction

    task automatic restart_frame();
        ph = PH_FIRST;
        body_pos = 0;
        count_byte = '0;
        crc_run = CRC_INIT;
        unit_got = '0;
        fn_got = '0;
        for (int k = 0; k < 4; k++)
            payload[k] = '0;
    endtask

    task automatic close_frame();
        mrr_result_t r;
        logic [15:0] w1;
        logic [15:0] w2;
        r = '0;
        armed = 1'b0;
        ph = PH_IDLE;
        if (crc_run != 16'h0000)
            r.status = ST_CRC_ERR;
        else if (fn_got[7])
        begin
            r.status = ST_EXCEPTION;
            r.exception_code = count_byte;
        end
        else if (unit_got != cfg.expected_unit)
            r.status = ST_UNIT_ERR;
        else if (cfg.value_type <= VT_I16)
        begin
            if (count_byte != 8'd2)
                r.status = ST_SIZE_ERR;
            else
            begin
                r.status = ST_OK;
                r.value = {16'h0000, pair(payload[0], payload[1])};
                if (cfg.value_type == VT_I16 && r.value[15])
                    r.value[31:16] = 16'hFFFF;
            end
        end
        else if (cfg.value_type <= VT_FLOAT)
        begin
            if (count_byte != 8'd4)
                r.status = ST_SIZE_ERR;
            else
            begin
                r.status = ST_OK;
                w1 = pair(payload[0], payload[1]);
                w2 = pair(payload[2], payload[3]);
                r.value = cfg.lo_word_first ? {w2, w1} : {w1, w2};
            end
        end
        else
            r.status = ST_SIZE_ERR;
        pending_replies.push_back(r);
    endtask

    task automatic take_rx(input logic [7:0] b);
        int dlen;
        int span;
        case (ph)
            PH_FIRST:
            begin
                if (b != 8'h00)
                begin
                    if (cfg.brace_mode)
                    begin
                        if (b == BIN_OPEN)
                        begin
                            ph = PH_UNIT;
                            idle_ticks = '0;
                        end
                    end
                    else
                    begin
                        unit_got = b;
                        crc_run = crc16_byte(crc_run, b);
                        ph = PH_FUNC;
                        idle_ticks = '0;
                    end
                end
            end
            PH_UNIT:
            begin
                unit_got = b;
                crc_run = crc16_byte(crc_run, b);
                ph = PH_FUNC;
            end
            PH_FUNC:
            begin
                fn_got = b;
                crc_run = crc16_byte(crc_run, b);
                ph = PH_COUNT;
            end
            PH_COUNT:
            begin
                if (fn_got == 8'd3 || fn_got == 8'd4 || fn_got[7])
                begin
                    count_byte = b;
                    crc_run = crc16_byte(crc_run, b);
                    body_pos = 0;
                    ph = PH_BODY;
                    idle_ticks = '0;
                end
                else
                    restart_frame();
            end
            PH_BODY:
            begin
                dlen = fn_got[7] ? 0 : int'(count_byte);
                span = dlen + 2 + (cfg.brace_mode ? 1 : 0);
                if (body_pos < dlen + 2)
                begin
                    if (body_pos < 4 && body_pos < dlen)
                        payload[body_pos[1:0]] = b;
                    crc_run = crc16_byte(crc_run, b);
                end
                if (body_pos >= dlen + 2 && b != BIN_CLOSE)
                    restart_frame();
                else
                begin
                    body_pos++;
                    if (body_pos >= span)
                        close_frame();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic absorb_item(input logic [1:0] f, input logic [7:0] b);
        mrr_result_t r;
        if (f == FN_ARM)
        begin
            armed = 1'b1;
            idle_ticks = '0;
            restart_frame();
        end
        else if (armed)
        begin
            if (f == FN_BYTE)
                take_rx(b);
            else if (f == FN_TICK)
            begin
                if (idle_ticks != 16'hFFFF)
                    idle_ticks++;
                if (idle_ticks >= cfg.timeout_ms)
                begin
                    armed = 1'b0;
                    restart_frame();
                    ph = PH_IDLE;
                    r = '0;
                    r.status = ST_TIMEOUT;
                    pending_replies.push_back(r);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.brace_mode = 1'b0;
            cfg.expected_unit = DEFAULT_UNIT;
            cfg.value_type = VT_U16;
            cfg.lo_byte_first = 1'b0;
            cfg.lo_word_first = 1'b0;
            cfg.timeout_ms = DEFAULT_TIMEOUT;
            armed = 1'b0;
            idle_ticks = '0;
            restart_frame();
            ph = PH_IDLE;
            pending_replies.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BRACE_MODE:     cfg.brace_mode = cfg_data[0];
                    REG_EXPECTED_UNIT:  cfg.expected_unit = cfg_data[7:0];
                    REG_VALUE_TYPE:     cfg.value_type = cfg_data[2:0];
                    REG_LO_BYTE_FIRST:  cfg.lo_byte_first = cfg_data[0];
                    REG_LO_WORD_FIRST:  cfg.lo_word_first = cfg_data[0];
                    REG_TIMEOUT_MS:     cfg.timeout_ms = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected reply: status %0d value %h exception %h",
                                 status, value, exception_code);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status || value !== want.value ||
                        exception_code !== want.exception_code)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0d/%h/%h, got %0d/%h/%h",
                                     want.status, want.value, want.exception_code,
                                     status, value, exception_code);
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_item(func, rx_byte);
            outstanding = pending_replies.size();
        end
    end

endmodule

### dv/tb.sv
module tb;
    import mrr_pkg::*;

    localparam logic [1:0] FN_IGNORED = 2'd3;
    localparam logic [2:0] VT_U32 = 3'd2;
    localparam logic [2:0] VT_I32 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_GOAL = 1550;
    localparam int HOLD_CYCLES = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            func;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            status;
    logic [31:0]           value;
    logic [7:0]            exception_code;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int       errors;
    int       outstanding;
    int       cycles;
    int       items_sent;
    bit       in_gaps_on = 1'b1;
    bit       out_stalls_on = 1'b1;
    bit       hold_request;
    mrr_cfg_t cur;

    modbus_response_receiver u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .value          (value),
        .exception_code (exception_code),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    reply_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .value          (value),
        .exception_code (exception_code),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_stall <= out_stalls_on && ($urandom_range(99) < 10);
        end
    end

    function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [7:0] b);
        in_valid <= 1'b1;
        func <= f;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (f != FN_IGNORED)
            items_sent++;
        if (in_gaps_on && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            func <= 2'($urandom_range(3));
            rx_byte <= 8'($urandom_range(255));
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] unit, input logic [7:0] fn,
                              input logic [7:0] count, input bit bad_crc, input bit bad_stop,
                              input bit junk_first, input int tick_pct);
        logic [7:0]  bytes_q [$];
        logic [15:0] crc;
        logic [7:0]  stray;
        bytes_q.push_back(unit);
        bytes_q.push_back(fn);
        bytes_q.push_back(count);
        if (!fn[7])
            repeat (count) bytes_q.push_back(8'($urandom_range(255)));
        crc = CRC_INIT;
        foreach (bytes_q[k])
            crc = crc_add(crc, bytes_q[k]);
        if (bad_crc)
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        bytes_q.push_back(crc[7:0]);
        bytes_q.push_back(crc[15:8]);
        if (cur.brace_mode)
        begin
            bytes_q.push_front(BIN_OPEN);
            stray = 8'($urandom_range(255));
            if (stray == BIN_CLOSE)
                stray = ~BIN_CLOSE;
            bytes_q.push_back(bad_stop ? stray : BIN_CLOSE);
        end
        if (junk_first)
        begin
            stray = cur.brace_mode ? 8'($urandom_range(255)) : 8'h00;
            if (stray == BIN_OPEN)
                stray = 8'h00;
            bytes_q.push_front(stray);
        end
        foreach (bytes_q[k])
        begin
            if ($urandom_range(99) < tick_pct)
                send_item(FN_TICK, 8'($urandom_range(255)));
            send_item(FN_BYTE, bytes_q[k]);
        end
    endtask

    task automatic random_frame();
        logic [7:0] unit;
        logic [7:0] fn;
        logic [7:0] count;
        int r;
        unit = ($urandom_range(99) < 85) ? cur.expected_unit : 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 70)
            fn = 8'($urandom_range(3, 4));
        else if (r < 85)
            fn = EXC_FLAG | 8'($urandom_range(255));
        else
            fn = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 70)
            count = (cur.value_type <= VT_I16) ? 8'd2 : 8'd4;
        else if (r < 97)
            count = 8'($urandom_range(8));
        else
            count = 8'($urandom_range(9, 255));
        send_frame(unit, fn, count, $urandom_range(99) < 8, $urandom_range(99) < 8,
                   $urandom_range(99) < 10, 3);
    endtask

    task automatic random_sequence();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 75)
        begin
            if ($urandom_range(19) != 0)
                send_item(FN_ARM, 8'($urandom_range(255)));
            random_frame();
        end
        else if (r < 87)
        begin
            repeat ($urandom_range(1, 4))
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
        else
        begin
            n = (cur.timeout_ms <= 16'd40) ? int'(cur.timeout_ms) + 1
                                           : int'($urandom_range(1, 6));
            send_item(FN_ARM, 8'($urandom_range(255)));
            repeat (n)
                send_item(FN_TICK, 8'($urandom_range(255)));
        end
    endtask

    // leaves the receiver disarmed with one reply to a frame with a good CRC
    task automatic close_out();
        send_item(FN_ARM, 8'($urandom_range(255)));
        send_frame((cur.expected_unit == 8'h00) ? DEFAULT_UNIT : cur.expected_unit,
                   8'h03, 8'd2, 1'b0, 1'b0, 1'b0, 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v,
                             input int w);
        logic [15:0] mask;
        mask = 16'((32'd1 << w) - 1);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= (16'($urandom) & ~mask) | (v & mask);
        @(posedge clk);
    endtask

    task automatic load_cfg(input mrr_cfg_t c, input bit spare_writes);
        write_reg(REG_BRACE_MODE, 16'(c.brace_mode), 1);
        write_reg(REG_EXPECTED_UNIT, 16'(c.expected_unit), 8);
        write_reg(REG_VALUE_TYPE, 16'(c.value_type), 3);
        write_reg(REG_LO_BYTE_FIRST, 16'(c.lo_byte_first), 1);
        write_reg(REG_LO_WORD_FIRST, 16'(c.lo_word_first), 1);
        write_reg(REG_TIMEOUT_MS, c.timeout_ms, 16);
        if (spare_writes)
        begin
            write_reg(REG_UNUSED_LO, 16'($urandom), 16);
            write_reg(REG_UNUSED_HI, 16'($urandom), 16);
        end
        cfg_we <= 1'b0;
        cur = c;
        @(posedge clk);
    endtask

    function automatic mrr_cfg_t pick_cfg(input int n);
        mrr_cfg_t c;
        c.brace_mode = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       c.expected_unit = 8'h00;
            1:       c.expected_unit = 8'hFF;
            default: c.expected_unit = 8'($urandom_range(1, 255));
        endcase
        c.value_type = 3'($urandom_range(7));
        c.lo_byte_first = 1'($urandom_range(1));
        c.lo_word_first = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       c.timeout_ms = 16'd1;
            1:       c.timeout_ms = 16'($urandom_range(2, 40));
            2:       c.timeout_ms = DEFAULT_TIMEOUT;
            default: c.timeout_ms = 16'($urandom_range(41, 65535));
        endcase
        case (n)
            0:
            begin
                c.brace_mode = 1'b1;
                c.expected_unit = 8'hFF;
                c.value_type = VT_FLOAT;
                c.lo_byte_first = 1'b1;
                c.lo_word_first = 1'b1;
                c.timeout_ms = 16'hFFFF;
            end
            1:
            begin
                c.brace_mode = 1'b0;
                c.expected_unit = 8'h00;
                c.value_type = VT_U16;
                c.lo_byte_first = 1'b0;
                c.lo_word_first = 1'b0;
                c.timeout_ms = 16'd0;
            end
            2:
            begin
                c.brace_mode = 1'b0;
                c.expected_unit = DEFAULT_UNIT;
                c.value_type = VT_I16;
                c.timeout_ms = 16'd12;
            end
            3:
            begin
                c.brace_mode = 1'b1;
                c.value_type = VT_U32;
                c.timeout_ms = 16'd30;
            end
            4:       c.value_type = VT_I32;
            5:       c.value_type = 3'($urandom_range(5, 7));
            default:
            begin
            end
        endcase
        return c;
    endfunction

    initial
    begin
        int phase_no;
        int target;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_ARM;
        rx_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        cur.brace_mode = 1'b0;
        cur.expected_unit = DEFAULT_UNIT;
        cur.value_type = VT_U16;
        cur.lo_byte_first = 1'b0;
        cur.lo_word_first = 1'b0;
        cur.timeout_ms = DEFAULT_TIMEOUT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not armed yet: all of these are dropped
        send_item(FN_BYTE, 8'h55);
        send_item(FN_TICK, 8'hAA);
        send_item(FN_IGNORED, 8'hFF);
        send_item(FN_ARM, 8'h00);
        send_frame(DEFAULT_UNIT, 8'h03, 8'd2, 1'b0, 1'b0, 1'b1, 0);
        send_item(FN_ARM, 8'hFF);
        send_frame(DEFAULT_UNIT, 8'h83, 8'h02, 1'b0, 1'b0, 1'b0, 0);
        // unsupported function, then a frame without a new arm
        send_item(FN_ARM, 8'h00);
        send_item(FN_BYTE, DEFAULT_UNIT);
        send_item(FN_BYTE, 8'h10);
        send_item(FN_BYTE, 8'h00);
        send_frame(DEFAULT_UNIT, 8'h04, 8'd2, 1'b0, 1'b0, 1'b0, 0);
        drain();

        phase_no = 0;
        while (items_sent < ITEM_GOAL)
        begin
            load_cfg(pick_cfg(phase_no), (phase_no % 3) == 0);
            in_gaps_on = (phase_no != 3);
            out_stalls_on = (phase_no != 3);
            if (phase_no == 2)
            begin
                hold_request = 1'b1;
                repeat (14)
                begin
                    send_item(FN_ARM, 8'($urandom_range(255)));
                    send_frame(cur.expected_unit, 8'h03, 8'd2, 1'b0, 1'b0, 1'b0, 0);
                end
            end
            target = items_sent + 150;
            while (items_sent < target && items_sent < ITEM_GOAL)
                random_sequence();
            close_out();
            drain();
            phase_no++;
        end
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
        repeat (8) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### modbus_response_receiver.f
design/mrr_pkg.sv
design/mrr_parser.sv
design/mrr_out_buf.sv
design/modbus_response_receiver.sv
dv/reply_checker.sv
dv/tb.sv
